// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared defaults and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    localparam int DEF_MAX_NODES = 256;
    localparam int DEF_MAX_ARCS  = 512;

    typedef struct packed {
        logic edge_first;
        logic edge_second;
        logic count_init;
        logic rev_init;
        logic v_inc;
        logic walk_start_v;
        logic walk_start_f;
        logic arc_read;
        logic push;
        logic idx_inc;
        logic pop;
        logic load;
        logic fin_read;
    } scc_cmd_t;

    typedef struct packed {
        logic edge_bad;
        logic scan_end;
        logic v_seen;
        logic idx_end;
        logic arc_hit;
        logic sp_last;
        logic fd_zero;
        logic node_seen;
        logic fwd;
    } scc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge loading and the two depth-first passes.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic               directed,
    input  wire logic               out_busy,
    input  wire scc_pkg::scc_stat_t stat,
    output scc_pkg::scc_cmd_t       cmd,
    output logic                    done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EDGE2 = 4'd1;
    localparam logic [3:0] S_FSCAN = 4'd2;
    localparam logic [3:0] S_ISSUE = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;
    localparam logic [3:0] S_RSCAN = 4'd7;
    localparam logic [3:0] S_RPOP  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       take;

    assign in_stall = (state_reg != S_IDLE) || (out_busy && mode);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        done       = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (!mode)
                    begin
                        cmd.edge_first = 1'b1;
                        if (!stat.edge_bad && !directed)
                        begin
                            state_next = S_EDGE2;
                        end
                    end
                    else
                    begin
                        cmd.count_init = 1'b1;
                        state_next     = S_FSCAN;
                    end
                end
            end
            S_EDGE2:
            begin
                cmd.edge_second = 1'b1;
                state_next      = S_IDLE;
            end
            S_FSCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.rev_init = 1'b1;
                    state_next   = S_RSCAN;
                end
                else if (stat.v_seen)
                begin
                    cmd.v_inc = 1'b1;
                end
                else
                begin
                    cmd.walk_start_v = 1'b1;
                    state_next       = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.arc_read = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.arc_hit)
                begin
                    cmd.push = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
                state_next = S_ISSUE;
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                if (stat.sp_last)
                begin
                    state_next = stat.fwd ? S_FSCAN : S_RSCAN;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_ISSUE;
            end
            S_RSCAN:
            begin
                if (stat.fd_zero)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.fin_read = 1'b1;
                    state_next   = S_RPOP;
                end
            end
            S_RPOP:
            begin
                if (stat.node_seen)
                begin
                    state_next = S_RSCAN;
                end
                else
                begin
                    cmd.walk_start_f = 1'b1;
                    state_next       = S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scc_dpath.sv =====
// ----------------------------------------------------------------------------
// scc_dpath
// Arc store, walk stack, finish stack, visited bits and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_dpath #(
    parameter int MaxNodes = scc_pkg::DEF_MAX_NODES,
    parameter int MaxArcs  = scc_pkg::DEF_MAX_ARCS,
    localparam int NW = $clog2(MaxNodes),
    localparam int SW = NW + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        src_node,
    input  wire logic [7:0]        dst_node,
    input  wire logic              directed,
    input  wire logic [8:0]        node_count,
    input  wire scc_pkg::scc_cmd_t cmd,
    output scc_pkg::scc_stat_t     stat,
    output logic [SW-1:0]          count,
    output logic                   overflow
);

    localparam int AW = (MaxArcs > 1) ? $clog2(MaxArcs) : 1;
    localparam int CW = $clog2(MaxArcs + 1);

    logic [NW-1:0]       arc_src_mem [MaxArcs];
    logic [NW-1:0]       arc_tgt_mem [MaxArcs];
    logic [NW-1:0]       stk_node_mem [MaxNodes];
    logic [CW-1:0]       stk_cur_mem [MaxNodes];
    logic [NW-1:0]       fin_mem [MaxNodes];

    logic [CW-1:0]       arc_total_reg;
    logic                ovf_reg;
    logic [MaxNodes-1:0] seen_reg;
    logic [MaxNodes-1:0] seen_next;
    logic                fwd_reg;
    logic [NW-1:0]       cur_node_reg;
    logic [CW-1:0]       cur_idx_reg;
    logic [SW-1:0]       sp_reg;
    logic [SW-1:0]       fd_reg;
    logic [SW-1:0]       v_reg;
    logic [SW-1:0]       count_reg;

    logic [NW-1:0]       e_src_reg;
    logic [NW-1:0]       e_dst_reg;
    logic [NW-1:0]       rd_src_reg;
    logic [NW-1:0]       rd_tgt_reg;
    logic [NW-1:0]       stk_node_rd_reg;
    logic [CW-1:0]       stk_cur_rd_reg;
    logic [NW-1:0]       fin_rd_reg;

    logic                edge_bad;
    logic                arc_we;
    logic [NW-1:0]       arc_wsrc;
    logic [NW-1:0]       arc_wtgt;
    logic [NW-1:0]       from_node;
    logic [NW-1:0]       to_node;
    logic [31:0]         need;

    assign need     = directed ? 32'd1 : 32'd2;
    assign edge_bad = (32'(src_node) >= MaxNodes) || (32'(dst_node) >= MaxNodes)
                   || (32'(arc_total_reg) + need > MaxArcs);

    assign arc_we   = (cmd.edge_first && !edge_bad) || cmd.edge_second;
    assign arc_wsrc = cmd.edge_second ? e_dst_reg : NW'(src_node);
    assign arc_wtgt = cmd.edge_second ? e_src_reg : NW'(dst_node);

    assign from_node = fwd_reg ? rd_src_reg : rd_tgt_reg;
    assign to_node   = fwd_reg ? rd_tgt_reg : rd_src_reg;

    assign stat.edge_bad  = edge_bad;
    assign stat.scan_end  = (32'(v_reg) >= 32'(node_count)) || (32'(v_reg) >= MaxNodes);
    assign stat.v_seen    = seen_reg[NW'(v_reg)];
    assign stat.idx_end   = cur_idx_reg >= arc_total_reg;
    assign stat.arc_hit   = (from_node == cur_node_reg) && !seen_reg[to_node];
    assign stat.sp_last   = sp_reg == SW'(1);
    assign stat.fd_zero   = fd_reg == '0;
    assign stat.node_seen = seen_reg[fin_rd_reg];
    assign stat.fwd       = fwd_reg;

    assign count    = count_reg;
    assign overflow = ovf_reg;

    always_comb
    begin
        seen_next = seen_reg;
        if (cmd.count_init || cmd.rev_init)
        begin
            seen_next = '0;
        end
        else if (cmd.walk_start_v)
        begin
            seen_next[NW'(v_reg)] = 1'b1;
        end
        else if (cmd.walk_start_f)
        begin
            seen_next[fin_rd_reg] = 1'b1;
        end
        else if (cmd.push)
        begin
            seen_next[to_node] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arc_total_reg <= '0;
            ovf_reg       <= 1'b0;
            seen_reg      <= '0;
            fwd_reg       <= 1'b0;
            cur_node_reg  <= '0;
            cur_idx_reg   <= '0;
            sp_reg        <= '0;
            fd_reg        <= '0;
            v_reg         <= '0;
            count_reg     <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (cmd.edge_first && edge_bad)
            begin
                ovf_reg <= 1'b1;
            end
            if (arc_we)
            begin
                arc_total_reg <= arc_total_reg + CW'(1);
            end
            if (cmd.count_init)
            begin
                fd_reg    <= '0;
                v_reg     <= '0;
                fwd_reg   <= 1'b1;
                count_reg <= '0;
            end
            if (cmd.rev_init)
            begin
                fwd_reg <= 1'b0;
            end
            if (cmd.v_inc)
            begin
                v_reg <= v_reg + SW'(1);
            end
            if (cmd.walk_start_v)
            begin
                cur_node_reg <= NW'(v_reg);
                cur_idx_reg  <= '0;
                sp_reg       <= SW'(1);
                v_reg        <= v_reg + SW'(1);
            end
            if (cmd.walk_start_f)
            begin
                cur_node_reg <= fin_rd_reg;
                cur_idx_reg  <= '0;
                sp_reg       <= SW'(1);
                count_reg    <= count_reg + SW'(1);
            end
            if (cmd.push)
            begin
                cur_node_reg <= to_node;
                cur_idx_reg  <= '0;
                sp_reg       <= sp_reg + SW'(1);
            end
            if (cmd.idx_inc)
            begin
                cur_idx_reg <= cur_idx_reg + CW'(1);
            end
            if (cmd.pop)
            begin
                sp_reg <= sp_reg - SW'(1);
                if (fwd_reg)
                begin
                    fd_reg <= fd_reg + SW'(1);
                end
            end
            if (cmd.load)
            begin
                cur_node_reg <= stk_node_rd_reg;
                cur_idx_reg  <= stk_cur_rd_reg;
            end
            if (cmd.fin_read)
            begin
                fd_reg <= fd_reg - SW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_first)
        begin
            e_src_reg <= NW'(src_node);
            e_dst_reg <= NW'(dst_node);
        end
        if (arc_we)
        begin
            arc_src_mem[AW'(arc_total_reg)] <= arc_wsrc;
            arc_tgt_mem[AW'(arc_total_reg)] <= arc_wtgt;
        end
        if (cmd.arc_read)
        begin
            rd_src_reg <= arc_src_mem[AW'(cur_idx_reg)];
            rd_tgt_reg <= arc_tgt_mem[AW'(cur_idx_reg)];
        end
        if (cmd.push)
        begin
            stk_node_mem[NW'(sp_reg - SW'(1))] <= cur_node_reg;
            stk_cur_mem[NW'(sp_reg - SW'(1))]  <= cur_idx_reg + CW'(1);
        end
        if (cmd.pop)
        begin
            stk_node_rd_reg <= stk_node_mem[NW'(sp_reg - SW'(2))];
            stk_cur_rd_reg  <= stk_cur_mem[NW'(sp_reg - SW'(2))];
            if (fwd_reg)
            begin
                fin_mem[NW'(fd_reg)] <= cur_node_reg;
            end
        end
        if (cmd.fin_read)
        begin
            fin_rd_reg <= fin_mem[NW'(fd_reg - SW'(1))];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scc_counter.sv =====
// ----------------------------------------------------------------------------
// scc_counter
// Strongly connected component counter over a stored arc list.
// ----------------------------------------------------------------------------
// directed add-edge writes one arc; undirected add-edge writes two (one arc store write port)
// count: a forward and a reverse depth-first pass; each node reached checks the stored arcs
//   one at a time through S_ISSUE and S_CHECK in each pass
// result leaves through an output register; edges load while it waits
// reset clears arc count, overflow flag, node_count and control; arc store is not cleared
`default_nettype none

module scc_counter #(
    parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
    parameter int MAX_ARCS  = scc_pkg::DEF_MAX_ARCS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       mode,
    input  wire logic [7:0] src_node,
    input  wire logic [7:0] dst_node,
    input  wire logic       directed,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [8:0]      component_count,
    output logic            edge_overflow
);

    localparam int SW = $clog2(MAX_NODES) + 1;

    scc_pkg::scc_cmd_t  cmd;
    scc_pkg::scc_stat_t stat;
    logic               done;
    logic [SW-1:0]      count;
    logic               overflow;

    logic [8:0]         node_count_reg;
    logic               out_valid_reg;
    logic [8:0]         cc_reg;
    logic               ovf_out_reg;

    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .directed (directed),
        .out_busy (out_valid_reg),
        .stat     (stat),
        .cmd      (cmd),
        .done     (done)
    );

    scc_dpath #(
        .MaxNodes (MAX_NODES),
        .MaxArcs  (MAX_ARCS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_node   (src_node),
        .dst_node   (dst_node),
        .directed   (directed),
        .node_count (node_count_reg),
        .cmd        (cmd),
        .stat       (stat),
        .count      (count),
        .overflow   (overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            cc_reg      <= 9'(count);
            ovf_out_reg <= overflow;
        end
    end

    assign out_valid       = out_valid_reg;
    assign component_count = cc_reg;
    assign edge_overflow   = ovf_out_reg;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// scc_counter testbench
// Loads edge lists and runs component counts against an in-bench component
// predictor. A directed table comes first, then random edge traffic mixed with
// counts, under random valid gaps and result stalls and several node counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int NODES     = scc_pkg::DEF_MAX_NODES;
    localparam int ARCS      = scc_pkg::DEF_MAX_ARCS;
    localparam int DOG_LIMIT = 4000000;
    localparam int N_RANDOM  = 1130;

    typedef enum logic {OP_ADD_EDGE = 1'b0, OP_COUNT = 1'b1} op_e;
    typedef enum int {ROW_ITEM, ROW_CFG} row_e;

    typedef struct packed {
        logic [8:0] count;
        logic       ovf;
    } scc_result_t;

    typedef struct {
        row_e        kind;
        op_e         op;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic        dir;
        logic [8:0]  cfg;
        bit          typed;
        scc_result_t res;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [8:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       mode = 1'b0;
    logic [7:0] src_node = '0;
    logic [7:0] dst_node = '0;
    logic       directed = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [8:0] component_count;
    logic       edge_overflow;

    scc_counter uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .src_node        (src_node),
        .dst_node        (dst_node),
        .directed        (directed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .component_count (component_count),
        .edge_overflow   (edge_overflow)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [7:0]  arc_from [ARCS];
    logic [7:0]  arc_to [ARCS];
    int          arc_total;
    bit          ovf_seen;
    int          start_nodes;
    bit          fwd_seen [NODES];
    bit          rev_seen [NODES];
    logic [7:0]  finish_order [NODES];
    int          finish_depth;
    logic [7:0]  walk_node [NODES];
    int          walk_cursor [NODES];

    scc_result_t expected_counts[$];
    stim_row_t   table_rows[$];
    int          transfers_in = 0;
    int          mismatches = 0;
    int          dog = 0;
    bit          quiet = 1'b0;
    bit          timed_out = 1'b0;

    function automatic bit seen_get(bit fwd, int n);
        return fwd ? fwd_seen[n] : rev_seen[n];
    endfunction

    function automatic void walk_arcs(int start, bit fwd);
        int sp;
        int node;
        int i;
        int a;
        int b;
        bit pushed;
        if (start >= NODES || seen_get(fwd, start))
            return;
        if (fwd) fwd_seen[start] = 1'b1; else rev_seen[start] = 1'b1;
        walk_node[0] = 8'(start);
        walk_cursor[0] = 0;
        sp = 1;
        while (sp > 0) begin
            node = walk_node[sp-1];
            pushed = 1'b0;
            for (i = walk_cursor[sp-1]; i < arc_total; i++) begin
                a = fwd ? arc_from[i] : arc_to[i];
                b = fwd ? arc_to[i] : arc_from[i];
                if (a == node && !seen_get(fwd, b)) begin
                    walk_cursor[sp-1] = i + 1;
                    if (sp < NODES) begin
                        if (fwd) fwd_seen[b] = 1'b1; else rev_seen[b] = 1'b1;
                        walk_node[sp] = 8'(b);
                        walk_cursor[sp] = 0;
                        sp++;
                        pushed = 1'b1;
                    end
                    break;
                end
            end
            if (!pushed) begin
                sp--;
                if (fwd && finish_depth < NODES)
                    finish_order[finish_depth++] = 8'(node);
            end
        end
    endfunction

    function automatic int count_components();
        int lim;
        int n;
        int total;
        lim = start_nodes < NODES ? start_nodes : NODES;
        total = 0;
        for (n = 0; n < NODES; n++)
        begin
            fwd_seen[n] = 1'b0;
            rev_seen[n] = 1'b0;
        end
        finish_depth = 0;
        for (n = 0; n < lim; n++)
            walk_arcs(n, 1'b1);
        while (finish_depth > 0) begin
            n = finish_order[--finish_depth];
            if (!rev_seen[n]) begin
                walk_arcs(n, 1'b0);
                total++;
            end
        end
        return total;
    endfunction

    function automatic void apply_item(logic op, logic [7:0] a, logic [7:0] b, logic dir);
        scc_result_t r;
        if (op == OP_ADD_EDGE) begin
            if (arc_total > ARCS - (dir ? 1 : 2)) begin
                ovf_seen = 1'b1;
            end else begin
                arc_from[arc_total] = a;
                arc_to[arc_total] = b;
                arc_total++;
                if (!dir) begin
                    arc_from[arc_total] = b;
                    arc_to[arc_total] = a;
                    arc_total++;
                end
            end
        end else begin
            r.count = 9'(count_components());
            r.ovf = ovf_seen;
            expected_counts.insert(expected_counts.size(), r);
        end
    endfunction

    // transfer monitor: prediction on input, comparison on output
    always @(posedge clk)
    begin
        scc_result_t want;
        if (in_valid && !in_stall)
        begin
            apply_item(mode, src_node, dst_node, directed);
            transfers_in <= transfers_in + 1;
        end
        if (out_valid && !out_stall)
        begin
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result count=%0d ovf=%0d",
                             component_count, edge_overflow);
            end else begin
                want = expected_counts.pop_front();
                if (component_count !== want.count || edge_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected count=%0d ovf=%0d, got count=%0d ovf=%0d",
                                 want.count, want.ovf, component_count, edge_overflow);
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            dog <= 0;
        else
            dog <= dog + 1;
        if (dog >= DOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result-side stall bursts
    initial
    begin
        forever
        begin
            repeat ($urandom_range(1, 40)) @(negedge clk);
            if (!quiet && $urandom_range(0, 2) != 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic send(logic op, logic [7:0] a, logic [7:0] b, logic dir);
        int target;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        target = transfers_in + 1;
        mode = op;
        src_node = a;
        dst_node = b;
        directed = dir;
        in_valid = 1'b1;
        do @(negedge clk); while (transfers_in != target);
    endtask

    task automatic write_node_count(logic [8:0] value);
        in_valid = 1'b0;
        @(negedge clk);
        wait (expected_counts.size() == 0);
        @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_wdata = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        start_nodes = int'(value);
    endtask

    task automatic add_row(row_e k, op_e op, int a, int b, int dir, int cfg,
                           int typed, int cnt, int ovf);
        stim_row_t r;
        r.kind = k;
        r.op = op;
        r.src = 8'(a);
        r.dst = 8'(b);
        r.dir = 1'(dir);
        r.cfg = 9'(cfg);
        r.typed = 1'(typed);
        r.res.count = 9'(cnt);
        r.res.ovf = 1'(ovf);
        table_rows.insert(table_rows.size(), r);
    endtask

    function automatic logic [7:0] pick_node();
        return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int k;
        int phase;
        int lim;
        stim_row_t r;
        scc_result_t typed_res;
        arc_total = 0;
        ovf_seen = 1'b0;
        start_nodes = 0;

        add_row(ROW_ITEM, OP_COUNT, 0, 0, 0, 0, 1, 0, 0);
        add_row(ROW_CFG, OP_COUNT, 0, 0, 0, 1, 0, 0, 0);
        add_row(ROW_ITEM, OP_COUNT, 0, 0, 0, 0, 1, 1, 0);
        add_row(ROW_CFG, OP_COUNT, 0, 0, 0, 256, 0, 0, 0);
        add_row(ROW_ITEM, OP_COUNT, 0, 0, 0, 0, 1, 256, 0);
        add_row(ROW_ITEM, OP_ADD_EDGE, 0, 1, 1, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_ADD_EDGE, 1, 0, 1, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_COUNT, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_ADD_EDGE, 255, 254, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_ADD_EDGE, 7, 7, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_ADD_EDGE, 3, 200, 1, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_ADD_EDGE, 200, 2, 1, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_ADD_EDGE, 2, 3, 1, 0, 0, 0, 0);
        add_row(ROW_CFG, OP_COUNT, 0, 0, 0, 4, 0, 0, 0);
        add_row(ROW_ITEM, OP_COUNT, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_COUNT, 255, 255, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, OP_COUNT, 0, 0, 0, 255, 0, 0, 0);
        add_row(ROW_ITEM, OP_COUNT, 170, 85, 1, 0, 0, 0, 0);
        add_row(ROW_CFG, OP_COUNT, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_COUNT, 0, 0, 0, 0, 0, 0, 0);

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
        begin
            r = table_rows[i];
            if (r.kind == ROW_CFG)
                write_node_count(r.cfg);
            else
            begin
                send(r.op, r.src, r.dst, r.dir);
                if (r.typed)
                begin
                    typed_res = expected_counts[expected_counts.size() - 1];
                    if (typed_res !== r.res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row %0d: predicted count=%0d ovf=%0d, table %0d/%0d",
                                     i, typed_res.count, typed_res.ovf, r.res.count, r.res.ovf);
                    end
                end
            end
        end

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_node_count(9'd16);
                1: write_node_count(9'd2);
                2: write_node_count(9'($urandom_range(0, 40)));
                3: write_node_count(9'd32);
                default: write_node_count(9'd8);
            endcase
            lim = N_RANDOM / 5;
            if (phase == 4)
                quiet = 1'b1;
            for (k = 0; k < lim; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                    send(OP_COUNT, 8'($urandom), 8'($urandom), 1'($urandom));
                else
                    send(OP_ADD_EDGE, pick_node(), pick_node(), 1'($urandom));
            end
            send(OP_COUNT, 8'($urandom), 8'($urandom), 1'($urandom));
        end

        in_valid = 1'b0;
        wait (expected_counts.size() == 0);
        repeat (50) @(negedge clk);
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
